@@ hdl/defective_pixel_correction_unit_macros.svh @@
// assertion macros shared by the defective pixel correction checks
`ifndef DEFECTIVE_PIXEL_CORRECTION_UNIT_MACROS_SVH
`define DEFECTIVE_PIXEL_CORRECTION_UNIT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define DPC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("dpc check failed");

// next-cycle implication
`define DPC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("dpc check failed");

`endif

@@ hdl/dpc_pkg.sv @@
// types, constants and helper functions for the defective pixel correction unit
package dpc_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned DimW       = 13;
  localparam int unsigned RowW       = 13;
  localparam int unsigned ThrW       = 8;
  localparam int unsigned SumW       = 11;
  localparam int unsigned CntW       = 4;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned HeightCap  = 4096;
  localparam int unsigned StepW      = 4;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned DataW      = 32;

  localparam logic [PixW-1:0]  PixMax    = 8'd255;
  localparam logic [DimW-1:0]  WidthRst  = 13'd2464;
  localparam logic [DimW-1:0]  HeightRst = 13'd2056;
  localparam logic [ThrW-1:0]  ThrRst    = 8'd50;
  localparam logic [StepW-1:0] StepLast  = 4'd8;
  localparam logic [2:0]       DetCtrIdx = 3'd7;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DET_RD,
    ST_DET_WR,
    ST_OUT_RD0,
    ST_OUT_CHK,
    ST_OUT_RD,
    ST_OUT_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [DimW-1:0] frame_width;
    logic [DimW-1:0] frame_height;
    logic [ThrW-1:0] threshold;
    logic            restart;
  } cfg_t;

  // row and column offsets coded 0, 1, 2 for -1, 0, +1
  typedef struct packed {
    logic [1:0] dr;
    logic [1:0] dc;
  } off_t;

  localparam off_t CenterOff = '{dr: 2'd1, dc: 2'd1};

  // neighbour order: top row, middle left/right, bottom row (lower right last)
  function automatic off_t nb_off(input logic [2:0] k);
    off_t o;
    unique case (k)
      3'd0:    o = '{dr: 2'd0, dc: 2'd0};
      3'd1:    o = '{dr: 2'd0, dc: 2'd1};
      3'd2:    o = '{dr: 2'd0, dc: 2'd2};
      3'd3:    o = '{dr: 2'd1, dc: 2'd0};
      3'd4:    o = '{dr: 2'd1, dc: 2'd2};
      3'd5:    o = '{dr: 2'd2, dc: 2'd0};
      3'd6:    o = '{dr: 2'd2, dc: 2'd1};
      default: o = '{dr: 2'd2, dc: 2'd2};
    endcase
    return o;
  endfunction

  // (r + dr - 1) mod 3
  function automatic logic [1:0] mod3_add(input logic [1:0] r, input logic [1:0] dr);
    logic [2:0] s;
    logic [1:0] m;
    s = 3'(r) + 3'(dr) + 3'd2;
    case (s) inside
      3'd0, 3'd3, 3'd6: m = 2'd0;
      3'd1, 3'd4, 3'd7: m = 2'd1;
      default:          m = 2'd2;
    endcase
    return m;
  endfunction

  function automatic logic [1:0] mod3_inc(input logic [1:0] r);
    return (r == 2'd2) ? 2'd0 : r + 2'd1;
  endfunction

  // ceil(2^16 / c), exact floor division for sums up to 2040
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] c);
    logic [RecipW-1:0] r;
    case (c)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/defective_pixel_correction_unit.sv @@
// Defective pixel correction over a 3x3 neighbourhood, streamed in raster order.
// Input channel: pixel_in_i and filler_i with in_valid_i / in_stall_o; a transfer
// happens when valid is high and stall is low. Output channel: pixel_out_o,
// was_corrected_o and end_of_frame_o with out_valid_o / out_stall_i.
// Results lag the input stream by two rows plus two pixels; filler items after
// the last pixel of a frame drain the remaining results.
// Each item is handled by a sequencer that reads the pixel and flag line stores
// through one read port each: an ignored filler is taken in 1 cycle, any other
// item needs at least 2 cycles and up to 24 for an interior pixel that needs
// detection plus correction (two passes of eight reads, one per cycle, on the
// line store read ports).
// The output register holds a result while the receiver stalls; the next item
// is taken and worked on meanwhile, and only its result waits for the register.
// Reset restores the register defaults and the frame position; the line stores
// need no clearing since every entry read was written earlier in the frame.
// Writing frame width or height restarts the frame.
module defective_pixel_correction_unit
  import dpc_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PixW-1:0]  pixel_in_i,
  input  logic             filler_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PixW-1:0]  pixel_out_o,
  output logic             was_corrected_o,
  output logic             end_of_frame_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;

  dpc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  dpc_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_in_i     (pixel_in_i),
    .filler_i       (filler_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .was_corrected_o(was_corrected_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

@@ hdl/dpc_ram.sv @@
// simple dual-port synchronous memory with registered read data
module dpc_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dpc_regs.sv @@
// configuration registers behind the apb-style port
module dpc_regs
  import dpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [ThrW-1:0] thr_q, thr_d;
  logic            wr_en;
  logic            restart;
  reg_idx_e        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    thr_d    = thr_q;
    restart  = 1'b0;
    prdata   = '0;
    unique case (idx)
      REG_WIDTH: begin
        prdata = DataW'(width_q);
        if (wr_en) begin
          width_d = pwdata[DimW-1:0];
          restart = 1'b1;
        end
      end
      REG_HEIGHT: begin
        prdata = DataW'(height_q);
        if (wr_en) begin
          height_d = pwdata[DimW-1:0];
          restart  = 1'b1;
        end
      end
      REG_THRESH: begin
        prdata = DataW'(thr_q);
        if (wr_en) begin
          thr_d = pwdata[ThrW-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
      thr_q    <= ThrRst;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      thr_q    <= thr_d;
    end
  end

  assign cfg_o = '{
    frame_width:  width_q,
    frame_height: height_q,
    threshold:    thr_q,
    restart:      restart
  };

endmodule

@@ hdl/dpc_core.sv @@
// line-store sequencer: detection, correction and output register
module dpc_core
  import dpc_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PixW-1:0] pixel_in_i,
  input  logic            filler_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [PixW-1:0] pixel_out_o,
  output logic            was_corrected_o,
  output logic            end_of_frame_o
);

  localparam int unsigned ColW      = $clog2(LINE_DEPTH);
  localparam int unsigned WW        = $clog2(LINE_DEPTH + 1);
  localparam int unsigned XW        = WW + 1;
  localparam int unsigned LeadW     = WW + 2;
  localparam int unsigned HW        = RowW + 1;
  localparam int unsigned PixDepth  = 4 * LINE_DEPTH;
  localparam int unsigned FlagDepth = 3 * LINE_DEPTH;
  localparam int unsigned PixAw     = $clog2(PixDepth);
  localparam int unsigned FlagAw    = $clog2(FlagDepth);
  localparam int unsigned ProdW     = SumW + RecipW;

  function automatic logic [PixAw-1:0] pix_addr(input logic [1:0] r, input logic [ColW-1:0] c);
    return PixAw'(r) * PixAw'(LINE_DEPTH) + PixAw'(c);
  endfunction

  function automatic logic [FlagAw-1:0] flag_addr(input logic [1:0] r,
                                                  input logic [ColW-1:0] c);
    return FlagAw'(r) * FlagAw'(LINE_DEPTH) + FlagAw'(c);
  endfunction

  state_e state_q, state_d;

  logic [StepW-1:0] k_q;
  logic [SumW-1:0]  acc_q;
  logic [CntW-1:0]  cnt_q;
  logic [PixW-1:0]  ctr_q;
  logic             fl_q;
  logic [PixW-1:0]  cur_q;

  logic [ColW-1:0]  ix_q, fx_q, ox_q;
  logic [RowW-1:0]  iy_q, fy_q, oy_q;
  logic [1:0]       fr3_q, or3_q;
  logic [LeadW-1:0] lead_q;

  logic             out_valid_q;
  logic [PixW-1:0]  out_pix_q;
  logic             out_cor_q;
  logic             out_eof_q;

  logic [WW-1:0]    eff_w, w_last;
  logic [RowW-1:0]  eff_h;
  logic             ix_last, fx_last, ox_last;
  logic             f_on, o_on, drain, f_act, f_int, o_int, o_eof;
  logic             proc, fin_go;
  logic [2:0]       k_prev;
  off_t             det_off, nb;

  logic             pix_we, pix_re, flag_we, flag_re;
  logic [PixAw-1:0] pix_waddr, pix_raddr;
  logic [FlagAw-1:0] flag_waddr, flag_raddr;
  logic [PixW-1:0]  pix_rdata;
  logic             flag_rdata;
  logic             det_flag;

  logic [SumW-1:0]  tot;
  logic [PixW-1:0]  mean, diff;
  logic [ProdW-1:0] prod;

  // effective geometry
  always_comb begin
    if (cfg_i.frame_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_i.frame_width) > LINE_DEPTH) begin
      eff_w = WW'(LINE_DEPTH);
    end else begin
      eff_w = WW'(cfg_i.frame_width);
    end
    if (cfg_i.frame_height == '0) begin
      eff_h = RowW'(1);
    end else if (32'(cfg_i.frame_height) > HeightCap) begin
      eff_h = RowW'(HeightCap);
    end else begin
      eff_h = cfg_i.frame_height;
    end
  end

  assign w_last  = eff_w - WW'(1);
  assign ix_last = (WW'(ix_q) == w_last);
  assign fx_last = (WW'(fx_q) == w_last);
  assign ox_last = (WW'(ox_q) == w_last);

  assign f_on  = lead_q >= (LeadW'(eff_w) + LeadW'(1));
  assign o_on  = lead_q >= ((LeadW'(eff_w) << 1) + LeadW'(2));
  assign drain = iy_q >= eff_h;
  assign f_act = f_on && (fy_q < eff_h);
  assign f_int = (fy_q != '0) && (fx_q != '0)
              && (HW'(fy_q) + HW'(2) <= HW'(eff_h))
              && (XW'(fx_q) + XW'(2) <= XW'(eff_w));
  assign o_int = (oy_q != '0) && (ox_q != '0)
              && (HW'(oy_q) + HW'(2) <= HW'(eff_h))
              && (XW'(ox_q) + XW'(2) <= XW'(eff_w));
  assign o_eof = o_on && (oy_q == eff_h - RowW'(1)) && ox_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign proc       = in_valid_i && (state_q == ST_IDLE) && (drain || !filler_i);
  assign fin_go     = !o_on || !out_valid_q || !out_stall_i;
  assign k_prev     = 3'(k_q - StepW'(1));

  assign det_off = (k_q[2:0] == DetCtrIdx) ? CenterOff : nb_off(k_q[2:0]);
  assign nb      = nb_off(k_q[2:0]);

  // detection arithmetic
  assign tot  = acc_q + SumW'(cur_q);
  assign mean = tot[SumW-1:3];
  assign diff = (ctr_q > mean) ? ctr_q - mean : mean - ctr_q;
  assign det_flag = f_int && ((ctr_q == '0) || (ctr_q == PixMax) || (diff > cfg_i.threshold));
  assign prod = ProdW'(acc_q) * ProdW'(recip(cnt_q));

  // next state and memory controls
  always_comb begin
    state_d    = state_q;
    pix_re     = 1'b0;
    pix_raddr  = pix_addr(oy_q[1:0], ox_q);
    flag_re    = 1'b0;
    flag_raddr = flag_addr(or3_q, ox_q);
    flag_we    = 1'b0;
    flag_waddr = flag_addr(fr3_q, fx_q);
    pix_we     = 1'b0;
    pix_waddr  = pix_addr(iy_q[1:0], ix_q);
    unique case (state_q)
      ST_IDLE: begin
        if (proc) begin
          if (f_act) begin
            state_d = f_int ? ST_DET_RD : ST_DET_WR;
          end else begin
            state_d = o_on ? ST_OUT_RD0 : ST_FINISH;
          end
        end
      end
      ST_DET_RD: begin
        pix_re    = (k_q != StepLast);
        pix_raddr = pix_addr(fy_q[1:0] + det_off.dr + 2'd3,
                             fx_q + ColW'(det_off.dc) - ColW'(1));
        if (k_q == StepLast) begin
          state_d = ST_DET_WR;
        end
      end
      ST_DET_WR: begin
        flag_we = 1'b1;
        state_d = o_on ? ST_OUT_RD0 : ST_FINISH;
      end
      ST_OUT_RD0: begin
        pix_re  = 1'b1;
        flag_re = 1'b1;
        state_d = ST_OUT_CHK;
      end
      ST_OUT_CHK: begin
        state_d = (o_int && flag_rdata) ? ST_OUT_RD : ST_FINISH;
      end
      ST_OUT_RD: begin
        pix_re     = (k_q != StepLast);
        flag_re    = (k_q != StepLast);
        pix_raddr  = pix_addr(oy_q[1:0] + nb.dr + 2'd3, ox_q + ColW'(nb.dc) - ColW'(1));
        flag_raddr = flag_addr(mod3_add(or3_q, nb.dr), ox_q + ColW'(nb.dc) - ColW'(1));
        if (k_q == StepLast) begin
          state_d = ST_OUT_DIV;
        end
      end
      ST_OUT_DIV: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) begin
          pix_we  = !drain;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  dpc_ram #(
    .Depth(PixDepth),
    .Width(PixW)
  ) u_pix_mem (
    .clk_i  (clk_i),
    .we_i   (pix_we),
    .waddr_i(pix_waddr),
    .wdata_i(cur_q),
    .re_i   (pix_re),
    .raddr_i(pix_raddr),
    .rdata_o(pix_rdata)
  );

  dpc_ram #(
    .Depth(FlagDepth),
    .Width(1)
  ) u_flag_mem (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(flag_waddr),
    .wdata_i(det_flag),
    .re_i   (flag_re),
    .raddr_i(flag_raddr),
    .rdata_o(flag_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cur_q <= pixel_in_i;
        acc_q <= '0;
        k_q   <= '0;
      end
      ST_DET_RD: begin
        k_q <= k_q + StepW'(1);
        if (k_q != '0) begin
          if (k_prev == DetCtrIdx) begin
            ctr_q <= pix_rdata;
          end else begin
            acc_q <= acc_q + SumW'(pix_rdata);
          end
        end
      end
      ST_OUT_CHK: begin
        ctr_q <= pix_rdata;
        fl_q  <= o_int && flag_rdata;
        acc_q <= '0;
        cnt_q <= '0;
        k_q   <= '0;
      end
      ST_OUT_RD: begin
        k_q <= k_q + StepW'(1);
        if ((k_q != '0) && !flag_rdata) begin
          acc_q <= acc_q + SumW'(pix_rdata);
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      ST_OUT_DIV: begin
        if (cnt_q != '0) begin
          ctr_q <= prod[RecipShift +: PixW];
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  // stream position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_q   <= '0;
      iy_q   <= '0;
      fx_q   <= '0;
      fy_q   <= '0;
      fr3_q  <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      or3_q  <= '0;
      lead_q <= '0;
    end else if (cfg_i.restart || ((state_q == ST_FINISH) && fin_go && o_eof)) begin
      ix_q   <= '0;
      iy_q   <= '0;
      fx_q   <= '0;
      fy_q   <= '0;
      fr3_q  <= '0;
      ox_q   <= '0;
      oy_q   <= '0;
      or3_q  <= '0;
      lead_q <= '0;
    end else if ((state_q == ST_FINISH) && fin_go) begin
      if (ix_last) begin
        ix_q <= '0;
        iy_q <= iy_q + RowW'(1);
      end else begin
        ix_q <= ix_q + ColW'(1);
      end
      if (f_on) begin
        if (fx_last) begin
          fx_q  <= '0;
          fy_q  <= fy_q + RowW'(1);
          fr3_q <= mod3_inc(fr3_q);
        end else begin
          fx_q <= fx_q + ColW'(1);
        end
      end
      if (o_on) begin
        if (ox_last) begin
          ox_q  <= '0;
          oy_q  <= oy_q + RowW'(1);
          or3_q <= mod3_inc(or3_q);
        end else begin
          ox_q <= ox_q + ColW'(1);
        end
      end else begin
        lead_q <= lead_q + LeadW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FINISH) && fin_go && o_on) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && fin_go && o_on) begin
      out_pix_q <= ctr_q;
      out_cor_q <= fl_q;
      out_eof_q <= o_eof;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_out_o     = out_pix_q;
  assign was_corrected_o = out_cor_q;
  assign end_of_frame_o  = out_eof_q;

endmodule

@@ hdl/dpc_checker.sv @@
// port-level checks for the defective pixel correction unit and their binding
`include "defective_pixel_correction_unit_macros.svh"

module dpc_checker
  import dpc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [PixW-1:0]  pixel_in_i,
  input logic             filler_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PixW-1:0]  pixel_out_o,
  input logic             was_corrected_o,
  input logic             end_of_frame_o,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [AddrW-1:0] paddr,
  input logic [DataW-1:0] pwdata,
  input logic [DataW-1:0] prdata,
  input logic             pready
);

  // a stalled result holds
  `DPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(pixel_out_o) && $stable(was_corrected_o) && $stable(end_of_frame_o))

  // the last pixel of a frame is a corner and never corrected
  `DPC_ASSERT_NOW(a_eof_border, out_valid_o && end_of_frame_o, !was_corrected_o)

  // a threshold write reads back on the following cycle
  `DPC_ASSERT_NEXT(a_thr_readback, psel && penable && pwrite && (paddr[3:2] == REG_THRESH), !psel || (paddr[3:2] != REG_THRESH) || (prdata[ThrW-1:0] == $past(pwdata[ThrW-1:0])))

  // the configuration port never inserts wait states
  `DPC_ASSERT_NOW(a_pready, psel && penable, pready)

endmodule

bind defective_pixel_correction_unit dpc_checker u_dpc_checker (.*);
